### hw/rtl/cidt_pkg.sv
package cidt_pkg;

   localparam int FUNC_W    = 2;
   localparam int REQ_ID_W  = 16;
   localparam int ORD_W     = 4;
   localparam int STATUS_W  = 3;
   localparam int RES_IDX_W = 4;
   localparam int COUNT_W   = 5;

   localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FIND    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_ORDINAL = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [REQ_ID_W-1:0] req_id;
      logic [ORD_W-1:0]    ordinal;
   } cidt_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [REQ_ID_W-1:0]  result_id;
      logic [RES_IDX_W-1:0] result_index;
      logic [COUNT_W-1:0]   entry_count;
   } cidt_rsp_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_SHIFT,
      SEQ_ORD_WAIT,
      SEQ_DONE
   } cidt_seq_state_type;

   // sequencer status toward the output stage
   typedef struct packed {
      logic idle;
      logic done;
   } cidt_stat_type;

endpackage

### hw/rtl/client_id_table.sv
// get by ordinal reads its entry directly; find, remove and explicit add scan one entry a cycle
// from the front and stop at a hit or after the last entry; remove then compacts the entries
// behind the hit; auto-assign rescans the table per candidate through the one memory read port
// throughput: one transaction in flight; the next is accepted once the response is loaded
// reset: synchronous, active high; clears count, sequencer and output valid, not the id memory
module client_id_table #(
   parameter int CAPACITY = 16,
   parameter int ID_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cidt_pkg::cidt_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cidt_pkg::cidt_rsp_type rsp_payload
);

   localparam int AW = $clog2(CAPACITY);

   // sequencer <-> memory
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [ID_BITS-1:0] rd_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ID_BITS-1:0] wr_data;

   // sequencer <-> output register
   cidt_pkg::cidt_stat_type seq_stat;
   cidt_pkg::cidt_rsp_type  seq_res;
   logic                    start;
   logic                    load;

   logic                    out_vld_ff, out_vld_in;
   cidt_pkg::cidt_rsp_type  out_data_ff;

   // one transaction at a time; a new one is taken as soon as the sequencer is back in idle,
   // even while the previous response still sits in the output register
   assign req_stall = !seq_stat.idle;
   assign start     = req_valid && seq_stat.idle;

   // finished response moves into the output register when it is empty or being drained
   assign load = seq_stat.done && (!out_vld_ff || !rsp_stall);

   always_comb begin
      out_vld_in = out_vld_ff;
      if (load) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= seq_res;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_data_ff;

   // id store, one write and one registered read port
   cidt_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ID_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // scan, compaction and append sequencer; holds the entry count
   cidt_seq #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req_payload),
      .take    (load),
      .stat    (seq_stat),
      .res     (seq_res),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

### hw/rtl/cidt_ram.sv
module cidt_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/cidt_seq.sv
module cidt_seq #(
   parameter int CAPACITY = 16,
   parameter int ID_BITS = 16,
   localparam int AW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int LIM_W = ((CW > ID_BITS) ? CW : ID_BITS) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cidt_pkg::cidt_req_type req,
   input  logic                 take,
   output cidt_pkg::cidt_stat_type stat,
   output cidt_pkg::cidt_rsp_type  res,
   output logic                 rd_en,
   output logic [AW-1:0]        rd_addr,
   input  logic [ID_BITS-1:0]   rd_data,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [ID_BITS-1:0]   wr_data
);

   localparam logic [ID_BITS-1:0] ID_MASK = '1;

   cidt_pkg::cidt_seq_state_type state_ff, state_in;
   logic [cidt_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic                         auto_ff, auto_in;
   logic [ID_BITS-1:0]           key_ff, key_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                ptr_ff, ptr_in;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]                cmp_idx_ff, cmp_idx_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic [AW-1:0]                wr_addr_ff, wr_addr_in;
   cidt_pkg::cidt_rsp_type       res_ff, res_in;

   logic [ID_BITS-1:0] req_key;
   logic [31:0]        cnt_w, cnt_inc_w, cnt_dec_w, idx_w, ptr_dec_w;
   logic [LIM_W-1:0]   cnt_l, mask_l, lim_l, key_l;
   logic               hit, scan_more, lim_hit, tbl_full;

   function automatic cidt_pkg::cidt_rsp_type fail_rsp(
      input logic [cidt_pkg::STATUS_W-1:0] st,
      input logic [cidt_pkg::COUNT_W-1:0]  cnt
   );
      cidt_pkg::cidt_rsp_type r;
      r.status       = st;
      r.result_id    = '0;
      r.result_index = '0;
      r.entry_count  = cnt;
      return r;
   endfunction

   assign req_key   = req.req_id[ID_BITS-1:0];
   assign cnt_w     = 32'(count_ff);
   assign cnt_inc_w = cnt_w + 32'd1;
   assign cnt_dec_w = cnt_w - 32'd1;
   assign idx_w     = 32'(cmp_idx_ff);
   assign ptr_dec_w = 32'(ptr_ff) - 32'd1;
   assign tbl_full  = (cnt_w == CAPACITY);

   assign hit       = cmp_vld_ff && (rd_data == key_ff);
   assign scan_more = (ptr_ff < count_ff);

   // candidates run from 1 up to min(count + 1, all-ones id)
   assign cnt_l   = LIM_W'(count_ff);
   assign mask_l  = LIM_W'(ID_MASK);
   assign lim_l   = (cnt_l >= mask_l) ? mask_l : cnt_l + LIM_W'(1);
   assign key_l   = LIM_W'(key_ff);
   assign lim_hit = (key_l >= lim_l);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= cidt_pkg::SEQ_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      auto_ff    <= auto_in;
      key_ff     <= key_in;
      ptr_ff     <= ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      wr_addr_ff <= wr_addr_in;
      res_ff     <= res_in;
   end

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      auto_in    = auto_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      wr_pend_in = wr_pend_ff;
      wr_addr_in = wr_addr_ff;
      res_in     = res_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = rd_data;

      case (state_ff)
         cidt_pkg::SEQ_IDLE: begin
            if (start) begin
               func_in    = req.func;
               key_in     = req_key;
               auto_in    = (req.func == cidt_pkg::FUNC_ADD) && (req_key == '0);
               ptr_in     = '0;
               cmp_vld_in = 1'b0;
               case (req.func)
                  cidt_pkg::FUNC_ADD: begin
                     if (req_key == '0) begin
                        key_in = ID_BITS'(1);
                     end
                     if ((req_key == '0) && tbl_full) begin
                        res_in   = fail_rsp(cidt_pkg::STATUS_FULL, cnt_w[4:0]);
                        state_in = cidt_pkg::SEQ_DONE;
                     end else begin
                        state_in = cidt_pkg::SEQ_SCAN;
                     end
                  end
                  cidt_pkg::FUNC_REMOVE, cidt_pkg::FUNC_FIND: begin
                     state_in = cidt_pkg::SEQ_SCAN;
                  end
                  cidt_pkg::FUNC_ORDINAL: begin
                     if (32'(req.ordinal) >= cnt_w) begin
                        res_in   = fail_rsp(cidt_pkg::STATUS_RANGE, cnt_w[4:0]);
                        state_in = cidt_pkg::SEQ_DONE;
                     end else begin
                        rd_en               = 1'b1;
                        rd_addr             = AW'(req.ordinal);
                        res_in.status       = cidt_pkg::STATUS_OK;
                        res_in.result_index = req.ordinal;
                        res_in.entry_count  = cnt_w[4:0];
                        state_in            = cidt_pkg::SEQ_ORD_WAIT;
                     end
                  end
                  default: begin
                     state_in = cidt_pkg::SEQ_IDLE;
                  end
               endcase
            end
         end

         cidt_pkg::SEQ_SCAN: begin
            if (scan_more) begin
               rd_en      = 1'b1;
               rd_addr    = ptr_ff[AW-1:0];
               ptr_in     = ptr_ff + CW'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = ptr_ff[AW-1:0];
            end else begin
               cmp_vld_in = 1'b0;
            end

            if (hit) begin
               cmp_vld_in = 1'b0;
               ptr_in     = '0;
               case (func_ff)
                  cidt_pkg::FUNC_ADD: begin
                     if (!auto_ff) begin
                        res_in   = fail_rsp(cidt_pkg::STATUS_DUP, cnt_w[4:0]);
                        state_in = cidt_pkg::SEQ_DONE;
                     end else if (lim_hit) begin
                        res_in   = fail_rsp(cidt_pkg::STATUS_FULL, cnt_w[4:0]);
                        state_in = cidt_pkg::SEQ_DONE;
                     end else begin
                        key_in = key_ff + ID_BITS'(1);
                     end
                  end
                  cidt_pkg::FUNC_REMOVE: begin
                     res_in.status       = cidt_pkg::STATUS_OK;
                     res_in.result_id    = 16'(key_ff);
                     res_in.result_index = idx_w[3:0];
                     ptr_in              = CW'(cmp_idx_ff) + CW'(1);
                     wr_pend_in          = 1'b0;
                     state_in            = cidt_pkg::SEQ_SHIFT;
                  end
                  cidt_pkg::FUNC_FIND: begin
                     res_in.status       = cidt_pkg::STATUS_OK;
                     res_in.result_id    = 16'(key_ff);
                     res_in.result_index = idx_w[3:0];
                     res_in.entry_count  = cnt_w[4:0];
                     state_in            = cidt_pkg::SEQ_DONE;
                  end
                  default: begin
                     state_in = cidt_pkg::SEQ_IDLE;
                  end
               endcase
            end else if (!scan_more && !cmp_vld_ff) begin
               if (func_ff == cidt_pkg::FUNC_ADD) begin
                  if (tbl_full) begin
                     res_in = fail_rsp(cidt_pkg::STATUS_FULL, cnt_w[4:0]);
                  end else begin
                     wr_en               = 1'b1;
                     wr_addr             = count_ff[AW-1:0];
                     wr_data             = key_ff;
                     count_in            = count_ff + CW'(1);
                     res_in.status       = cidt_pkg::STATUS_OK;
                     res_in.result_id    = 16'(key_ff);
                     res_in.result_index = cnt_w[3:0];
                     res_in.entry_count  = cnt_inc_w[4:0];
                  end
               end else begin
                  res_in = fail_rsp(cidt_pkg::STATUS_NOTFOUND, cnt_w[4:0]);
               end
               state_in = cidt_pkg::SEQ_DONE;
            end
         end

         cidt_pkg::SEQ_SHIFT: begin
            // read entry j, write it to j-1 on the following cycle
            if (wr_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wr_addr_ff;
               wr_data = rd_data;
            end
            if (scan_more) begin
               rd_en      = 1'b1;
               rd_addr    = ptr_ff[AW-1:0];
               wr_pend_in = 1'b1;
               wr_addr_in = ptr_dec_w[AW-1:0];
               ptr_in     = ptr_ff + CW'(1);
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  count_in           = count_ff - CW'(1);
                  res_in.entry_count = cnt_dec_w[4:0];
                  state_in           = cidt_pkg::SEQ_DONE;
               end
            end
         end

         cidt_pkg::SEQ_ORD_WAIT: begin
            res_in.result_id = 16'(rd_data);
            state_in         = cidt_pkg::SEQ_DONE;
         end

         cidt_pkg::SEQ_DONE: begin
            if (take) begin
               state_in = cidt_pkg::SEQ_IDLE;
            end
         end

         default: begin
            state_in = cidt_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign stat.idle = (state_ff == cidt_pkg::SEQ_IDLE);
   assign stat.done = (state_ff == cidt_pkg::SEQ_DONE);
   assign res       = res_ff;

endmodule

### hw/rtl/cidt_checker.sv
module cidt_checker #(
   parameter int CAPACITY = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input cidt_pkg::cidt_req_type req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input cidt_pkg::cidt_rsp_type rsp_payload
);

   // idle and empty right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // only one transaction in work at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

   // failures carry zero id and index
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != cidt_pkg::STATUS_OK)
      |-> (rsp_payload.result_id == '0) && (rsp_payload.result_index == '0))
      else $error("failure response with nonzero id or index");

   // count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 31) || (32'(rsp_payload.entry_count) <= CAPACITY))
      else $error("entry count above capacity");

endmodule

bind client_id_table cidt_checker #(.CAPACITY(CAPACITY)) u_cidt_checker (.*);

### test/tb_client_id_table.sv
module tb_client_id_table;
   timeunit 1ns;
   timeprecision 1ps;

   // table size as built into the dut defaults
   localparam int TABLE_DEPTH    = 16;
   localparam int RANDOM_ITEMS   = 1500;
   // watchdog margin over the longest auto-assign rescan, plus stall streaks
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 400;
   localparam int IDLE_PERCENT   = 22;
   localparam int REPORT_LIMIT   = 10;
   // no idling on either side while the issued count is in this window
   localparam int CALM_FIRST     = 700;
   localparam int CALM_LAST      = 1000;

   // one directed row: a request, how often to send it, and an optional
   // hand-written expectation
   typedef struct packed {
      cidt_pkg::cidt_req_type req;
      logic [4:0]             reps;
      logic                   typed;
      cidt_pkg::cidt_rsp_type rsp;
   } stim_row_type;

   localparam int PLAN_ROWS = 19;
   localparam stim_row_type PLAN [PLAN_ROWS] = '{
      // empty table right after reset
      '{'{cidt_pkg::FUNC_ORDINAL, 16'h0000, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_RANGE, 16'h0000, 4'd0, 5'd0}},
      '{'{cidt_pkg::FUNC_REMOVE, 16'hFFFF, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_NOTFOUND, 16'h0000, 4'd0, 5'd0}},
      '{'{cidt_pkg::FUNC_FIND, 16'h0000, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_NOTFOUND, 16'h0000, 4'd0, 5'd0}},
      // auto-assign, explicit top id, duplicate, find
      '{'{cidt_pkg::FUNC_ADD, 16'h0000, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_OK, 16'h0001, 4'd0, 5'd1}},
      '{'{cidt_pkg::FUNC_ADD, 16'hFFFF, 4'd15}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_OK, 16'hFFFF, 4'd1, 5'd2}},
      '{'{cidt_pkg::FUNC_ADD, 16'hFFFF, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_DUP, 16'h0000, 4'd0, 5'd2}},
      '{'{cidt_pkg::FUNC_FIND, 16'hFFFF, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_OK, 16'hFFFF, 4'd1, 5'd2}},
      // fill up with ids 2 to 15
      '{'{cidt_pkg::FUNC_ADD, 16'h0000, 4'd0}, 5'd14, 1'b0, '0},
      // full table: auto and explicit fail, duplicate wins over full; get by ordinal at both ends
      '{'{cidt_pkg::FUNC_ADD, 16'h0000, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_FULL, 16'h0000, 4'd0, 5'd16}},
      '{'{cidt_pkg::FUNC_ADD, 16'h1234, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_FULL, 16'h0000, 4'd0, 5'd16}},
      '{'{cidt_pkg::FUNC_ADD, 16'h0005, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_DUP, 16'h0000, 4'd0, 5'd16}},
      '{'{cidt_pkg::FUNC_ORDINAL, 16'h0000, 4'd15}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_OK, 16'h000F, 4'd15, 5'd16}},
      '{'{cidt_pkg::FUNC_ORDINAL, 16'hFFFF, 4'd0}, 5'd1, 1'b1,
        '{cidt_pkg::STATUS_OK, 16'h0001, 4'd0, 5'd16}},
      // remove in the middle, at the front and at the back
      '{'{cidt_pkg::FUNC_REMOVE, 16'h0008, 4'd0}, 5'd1, 1'b0, '0},
      '{'{cidt_pkg::FUNC_REMOVE, 16'h0001, 4'd0}, 5'd1, 1'b0, '0},
      '{'{cidt_pkg::FUNC_REMOVE, 16'h000F, 4'd0}, 5'd1, 1'b0, '0},
      // auto-assign reuses the lowest hole
      '{'{cidt_pkg::FUNC_ADD, 16'h0000, 4'd0}, 5'd1, 1'b0, '0},
      '{'{cidt_pkg::FUNC_ORDINAL, 16'h0000, 4'd13}, 5'd1, 1'b0, '0},
      '{'{cidt_pkg::FUNC_ORDINAL, 16'h0000, 4'd14}, 5'd1, 1'b0, '0}
   };

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   cidt_pkg::cidt_req_type req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   cidt_pkg::cidt_rsp_type rsp_payload;

   client_id_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // shadow copy of the id table
   logic [cidt_pkg::REQ_ID_W-1:0] id_tab [TABLE_DEPTH];
   int                            id_count = 0;
   int                            peak_count = 0;

   // results still owed by the dut, oldest first
   cidt_pkg::cidt_rsp_type pending_rsp [$];

   int  issued       = 0;
   int  results_seen = 0;
   int  mismatches   = 0;
   int  idle_cycles  = 0;
   int  status_seen [5] = '{default: 0};
   bit  calm         = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // position of an id in the shadow table, -1 when absent
   function automatic int find_pos(input logic [cidt_pkg::REQ_ID_W-1:0] id);
      for (int i = 0; i < id_count; i++) begin
         if (id_tab[i] == id) return i;
      end
      return -1;
   endfunction

   // smallest id from 1 upward not in the table, 0 when none is free
   function automatic logic [cidt_pkg::REQ_ID_W-1:0] lowest_unused();
      int top;
      top = id_count + 1;
      if (top > 16'hFFFF) top = 16'hFFFF;
      for (int c = 1; c <= top; c++) begin
         if (find_pos(cidt_pkg::REQ_ID_W'(c)) < 0) return cidt_pkg::REQ_ID_W'(c);
      end
      return '0;
   endfunction

   // applies one transaction to the shadow table and returns the result it owes
   function automatic cidt_pkg::cidt_rsp_type apply_request(input cidt_pkg::cidt_req_type r);
      cidt_pkg::cidt_rsp_type        o;
      int                            pos;
      logic [cidt_pkg::REQ_ID_W-1:0] cand;
      o = '0;
      o.status = cidt_pkg::STATUS_OK;
      pos = find_pos(r.req_id);
      case (r.func)
         cidt_pkg::FUNC_ADD: begin
            cand = r.req_id;
            if (cand == '0) begin
               cand = lowest_unused();
               if (cand == '0) o.status = cidt_pkg::STATUS_FULL;
            end else if (pos >= 0) begin
               o.status = cidt_pkg::STATUS_DUP;
            end
            // duplicate is reported ahead of a full table
            if (o.status == cidt_pkg::STATUS_OK && id_count >= TABLE_DEPTH)
               o.status = cidt_pkg::STATUS_FULL;
            if (o.status == cidt_pkg::STATUS_OK) begin
               id_tab[id_count] = cand;
               o.result_id      = cand;
               o.result_index   = cidt_pkg::RES_IDX_W'(id_count);
               id_count++;
            end
         end
         cidt_pkg::FUNC_REMOVE, cidt_pkg::FUNC_FIND: begin
            if (pos < 0) begin
               o.status = cidt_pkg::STATUS_NOTFOUND;
            end else begin
               o.result_id    = r.req_id;
               o.result_index = cidt_pkg::RES_IDX_W'(pos);
               if (r.func == cidt_pkg::FUNC_REMOVE) begin
                  // compaction keeps insertion order
                  for (int i = pos; i + 1 < id_count; i++) id_tab[i] = id_tab[i + 1];
                  id_count--;
               end
            end
         end
         default: begin
            if (r.ordinal >= id_count) begin
               o.status = cidt_pkg::STATUS_RANGE;
            end else begin
               o.result_id    = id_tab[r.ordinal];
               o.result_index = r.ordinal;
            end
         end
      endcase
      o.entry_count = cidt_pkg::COUNT_W'(id_count);
      if (id_count > peak_count) peak_count = id_count;
      return o;
   endfunction

   // random request shaped by the table contents; grow favors adds over removes
   function automatic cidt_pkg::cidt_req_type random_request(input bit grow);
      cidt_pkg::cidt_req_type r;
      int                     pick;
      int                     add_cut;
      int                     rem_cut;
      int                     src;
      r.func    = cidt_pkg::FUNC_ORDINAL;
      r.req_id  = cidt_pkg::REQ_ID_W'($urandom);
      r.ordinal = cidt_pkg::ORD_W'($urandom);
      pick      = $urandom_range(99, 0);
      add_cut   = grow ? 45 : 15;
      rem_cut   = add_cut + (grow ? 12 : 40);
      src       = $urandom_range(99, 0);
      if (pick < add_cut) begin
         r.func = cidt_pkg::FUNC_ADD;
         // auto-assign, small ids that collide, present ids, anything
         if (src < 50) r.req_id = '0;
         else if (src < 75) r.req_id = cidt_pkg::REQ_ID_W'($urandom_range(24, 1));
         else if (src < 90 && id_count > 0) r.req_id = id_tab[$urandom_range(id_count - 1, 0)];
      end else if (pick < rem_cut + (100 - rem_cut) / 2) begin
         r.func = (pick < rem_cut) ? cidt_pkg::FUNC_REMOVE : cidt_pkg::FUNC_FIND;
         if (src < 70 && id_count > 0) r.req_id = id_tab[$urandom_range(id_count - 1, 0)];
         else if (src < 85) r.req_id = cidt_pkg::REQ_ID_W'($urandom_range(24, 0));
      end else if (src < 60 && id_count > 0) begin
         r.ordinal = cidt_pkg::ORD_W'($urandom_range(id_count - 1, 0));
      end
      return r;
   endfunction

   // offers one transaction, records its expectation once accepted, then maybe idles
   task automatic issue(input cidt_pkg::cidt_req_type item, input bit typed,
                        input cidt_pkg::cidt_rsp_type hand_rsp);
      cidt_pkg::cidt_rsp_type predicted;
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_request(item);
      if (typed) predicted = hand_rsp;
      pending_rsp = {pending_rsp, predicted};
      status_seen[predicted.status]++;
      issued++;
      calm <= (issued >= CALM_FIRST && issued < CALM_LAST);
      if (!calm && $urandom_range(99, 0) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic flag_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch in %s of result %0d: expected %0h, got %0h",
                  field, results_seen, want, got);
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99, 0) < IDLE_PERCENT);
   end

   // result checker: each accepted result against the oldest expectation
   always @(posedge clock) begin
      cidt_pkg::cidt_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result with no transaction pending: %p", rsp_payload);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.status !== want.status)
               flag_field("status", 16'(want.status), 16'(rsp_payload.status));
            if (rsp_payload.result_id !== want.result_id)
               flag_field("result_id", want.result_id, rsp_payload.result_id);
            if (rsp_payload.result_index !== want.result_index)
               flag_field("result_index", 16'(want.result_index),
                          16'(rsp_payload.result_index));
            if (rsp_payload.entry_count !== want.entry_count)
               flag_field("entry_count", 16'(want.entry_count),
                          16'(rsp_payload.entry_count));
         end
         results_seen++;
      end
   end

   // watchdog: cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                  idle_cycles, pending_rsp.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      bit grow;
      grow = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int row = 0; row < PLAN_ROWS; row++) begin
         for (int k = 0; k < PLAN[row].reps; k++) begin
            issue(PLAN[row].req, PLAN[row].typed, PLAN[row].rsp);
         end
      end

      // random part, alternating fill and drain phases
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) grow = !grow;
         issue(random_request(grow), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // drain, then watch for stray results
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d transactions, %0d results, table occupancy peaked at %0d of %0d",
               issued, results_seen, peak_count, TABLE_DEPTH);
      $display("outcomes: ok %0d, full %0d, duplicate %0d, not found %0d, out of range %0d",
               status_seen[cidt_pkg::STATUS_OK], status_seen[cidt_pkg::STATUS_FULL],
               status_seen[cidt_pkg::STATUS_DUP], status_seen[cidt_pkg::STATUS_NOTFOUND],
               status_seen[cidt_pkg::STATUS_RANGE]);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/cidt_pkg.sv
hw/rtl/cidt_ram.sv
hw/rtl/cidt_seq.sv
hw/rtl/client_id_table.sv
hw/rtl/cidt_checker.sv
test/tb_client_id_table.sv
